>>> design/dqu_pkg.sv
package dqu_pkg;

    // ring store geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // word field widths
    localparam int ACT_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // action codes on the request channel
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DUMP       = 3'd4;

    // status codes on the response channel
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_DUMP,
        CMD_NOP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                  op;
        logic signed [DATA_W-1:0] value;
    } cmd_word_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_POP,
        BS_DUMP
    } back_state_t;

    // ring index step forward
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    // ring index step backward
    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        ring_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

endpackage

>>> design/dqu_if.sv
// request channel
interface dqu_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [dqu_pkg::ACT_W-1:0]              action;
    logic signed [dqu_pkg::DATA_W-1:0]      push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

// response channel
interface dqu_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [dqu_pkg::STAT_W-1:0]             status;
    logic signed [dqu_pkg::DATA_W-1:0]      value_out;
    logic                                   is_last;
    logic [dqu_pkg::OCC_W-1:0]              occupancy;

    modport source (output valid, output status, output value_out, output is_last,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input value_out, input is_last,
                    input occupancy, output ready);
endinterface

>>> design/dqu_front.sv
module dqu_front
(
    input  logic               clk,
    input  logic               rst_n,
    dqu_req_if.sink            req,
    output logic               cmd_valid,
    output dqu_pkg::cmd_word_t cmd,
    input  logic               cmd_take
);

    dqu_pkg::cmd_word_t          q_reg [dqu_pkg::QDEPTH];
    logic [dqu_pkg::QIDX_W-1:0]  wr_ptr_reg;
    logic [dqu_pkg::QIDX_W-1:0]  wr_ptr_next;
    logic [dqu_pkg::QIDX_W-1:0]  rd_ptr_reg;
    logic [dqu_pkg::QIDX_W-1:0]  rd_ptr_next;
    logic [dqu_pkg::QCNT_W-1:0]  qcnt_reg;
    logic [dqu_pkg::QCNT_W-1:0]  qcnt_next;
    dqu_pkg::cmd_word_t          new_cmd;
    logic                        push;
    logic                        pop;

    // classify the action code
    always_comb
    begin
        new_cmd.value = req.push_value;
        unique case (req.action)
            dqu_pkg::ACT_PUSH_FRONT: new_cmd.op = dqu_pkg::CMD_PUSH_FRONT;
            dqu_pkg::ACT_PUSH_BACK:  new_cmd.op = dqu_pkg::CMD_PUSH_BACK;
            dqu_pkg::ACT_POP_FRONT:  new_cmd.op = dqu_pkg::CMD_POP_FRONT;
            dqu_pkg::ACT_POP_BACK:   new_cmd.op = dqu_pkg::CMD_POP_BACK;
            dqu_pkg::ACT_DUMP:       new_cmd.op = dqu_pkg::CMD_DUMP;
            default:                 new_cmd.op = dqu_pkg::CMD_NOP;
        endcase
    end

    // queue handshake
    assign req.ready = (qcnt_reg != dqu_pkg::QCNT_W'(dqu_pkg::QDEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (qcnt_reg != '0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + dqu_pkg::QIDX_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + dqu_pkg::QIDX_W'(1) : rd_ptr_reg;
        qcnt_next   = qcnt_reg;
        if (push && !pop)
        begin
            qcnt_next = qcnt_reg + dqu_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            qcnt_next = qcnt_reg - dqu_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            qcnt_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            qcnt_reg   <= qcnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> design/dqu_back.sv
module dqu_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  dqu_pkg::cmd_word_t cmd,
    output logic               cmd_take,
    dqu_rsp_if.source          rsp
);

    dqu_pkg::back_state_t              state_reg;
    dqu_pkg::back_state_t              state_next;
    logic [dqu_pkg::IDX_W-1:0]         front_reg;
    logic [dqu_pkg::IDX_W-1:0]         front_next;
    logic [dqu_pkg::IDX_W-1:0]         back_reg;
    logic [dqu_pkg::IDX_W-1:0]         back_next;
    logic [dqu_pkg::CNT_W-1:0]         count_reg;
    logic [dqu_pkg::CNT_W-1:0]         count_next;
    logic [dqu_pkg::IDX_W-1:0]         addr_reg;
    logic [dqu_pkg::IDX_W-1:0]         addr_next;
    logic [dqu_pkg::CNT_W-1:0]         left_reg;
    logic [dqu_pkg::CNT_W-1:0]         left_next;

    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    logic [dqu_pkg::STAT_W-1:0]        status_reg;
    logic [dqu_pkg::STAT_W-1:0]        status_next;
    logic signed [dqu_pkg::DATA_W-1:0] value_reg;
    logic signed [dqu_pkg::DATA_W-1:0] value_next;
    logic                              last_reg;
    logic                              last_next;
    logic [dqu_pkg::OCC_W-1:0]         occ_reg;
    logic [dqu_pkg::OCC_W-1:0]         occ_next;

    logic signed [dqu_pkg::DATA_W-1:0] mem_reg [dqu_pkg::DEPTH];
    logic signed [dqu_pkg::DATA_W-1:0] rdata_reg;
    logic                              mem_we;
    logic [dqu_pkg::IDX_W-1:0]         mem_waddr;

    logic                              slot_free;
    logic                              load;
    logic [dqu_pkg::STAT_W-1:0]        ld_status;
    logic signed [dqu_pkg::DATA_W-1:0] ld_value;
    logic                              ld_last;

    assign slot_free = !rsp_valid_reg || rsp.ready;

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        cmd_take       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = back_reg;
        load           = 1'b0;
        ld_status      = dqu_pkg::ST_OK;
        ld_value       = '0;
        ld_last        = 1'b1;

        unique case (state_reg)
            dqu_pkg::BS_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_take = 1'b1;
                    unique case (cmd.op) inside
                        dqu_pkg::CMD_PUSH_FRONT, dqu_pkg::CMD_PUSH_BACK:
                        begin
                            load = 1'b1;
                            if (count_reg == dqu_pkg::CNT_W'(dqu_pkg::DEPTH))
                            begin
                                ld_status = dqu_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + dqu_pkg::CNT_W'(1);
                                if (cmd.op == dqu_pkg::CMD_PUSH_FRONT)
                                begin
                                    front_next = dqu_pkg::ring_prev(front_reg);
                                    mem_waddr  = dqu_pkg::ring_prev(front_reg);
                                end
                                else
                                begin
                                    back_next = dqu_pkg::ring_next(back_reg);
                                end
                            end
                        end
                        dqu_pkg::CMD_POP_FRONT, dqu_pkg::CMD_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                load      = 1'b1;
                                ld_status = dqu_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - dqu_pkg::CNT_W'(1);
                                state_next = dqu_pkg::BS_POP;
                                if (cmd.op == dqu_pkg::CMD_POP_FRONT)
                                begin
                                    addr_next  = front_reg;
                                    front_next = dqu_pkg::ring_next(front_reg);
                                end
                                else
                                begin
                                    addr_next = dqu_pkg::ring_prev(back_reg);
                                    back_next = dqu_pkg::ring_prev(back_reg);
                                end
                            end
                        end
                        dqu_pkg::CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                load      = 1'b1;
                                ld_status = dqu_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                addr_next  = front_reg;
                                left_next  = count_reg;
                                state_next = dqu_pkg::BS_DUMP;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            dqu_pkg::BS_POP:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    ld_value   = rdata_reg;
                    state_next = dqu_pkg::BS_IDLE;
                end
            end
            dqu_pkg::BS_DUMP:
            begin
                if (slot_free)
                begin
                    load     = 1'b1;
                    ld_value = rdata_reg;
                    ld_last  = (left_reg == dqu_pkg::CNT_W'(1));
                    if (ld_last)
                    begin
                        state_next = dqu_pkg::BS_IDLE;
                    end
                    else
                    begin
                        addr_next = dqu_pkg::ring_next(addr_reg);
                        left_next = left_reg - dqu_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = dqu_pkg::BS_IDLE;
            end
        endcase
    end

    // response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        occ_next       = occ_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ld_status;
            value_next     = ld_value;
            last_next      = ld_last;
            occ_next       = dqu_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqu_pkg::BS_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            left_reg      <= left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
        occ_reg    <= occ_next;
    end

    // ring store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_waddr] <= cmd.value;
        end
        rdata_reg <= mem_reg[addr_next];
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.value_out = value_reg;
    assign rsp.is_last   = last_reg;
    assign rsp.occupancy = occ_reg;

    // count stays within the ring
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dqu_pkg::CNT_W'(dqu_pkg::DEPTH))
        else $error("entry count beyond depth");

    // empty ring has matching ends
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (front_reg == back_reg))
        else $error("front and back differ on empty ring");

    // dump walk never runs past the held entries
    a_dump_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dqu_pkg::BS_DUMP) |-> ((left_reg != '0) && (left_reg <= count_reg)))
        else $error("dump walk count out of range");

    // a started pop delivers its word on the next free slot
    a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == dqu_pkg::BS_POP) && slot_free) |=>
            (rsp_valid_reg && (state_reg == dqu_pkg::BS_IDLE)))
        else $error("pop result not delivered");

endmodule

>>> design/double_ended_queue_unit.sv
// double-ended queue of signed 32-bit values on a 16-entry ring store
// req channel: one word per action (push front/back, pop front/back, dump);
//   push_value is used by pushes only, unknown action codes give a plain ok
// rsp channel: one word per action, a dump gives one word per held entry
//   front to back with is_last on the final one; occupancy follows the action
// path: a push, a refused push, an empty answer or an unknown code passes the
//   command queue and the response register; a pop or the first dump word
//   also passes the registered read of the ring store
// throughput: pushes one per cycle while rsp is not stalled; a pop holds the
//   back end until its word is loaded; a dump walks the entries one per cycle
//   while rsp is not stalled, through the single store read port
// a two-word command queue sits between the front and back ends, so req stays
//   ready while a result waits; once it fills, req.ready drops
// when rsp is stalled the result word holds and the back end waits
// reset: asynchronous active low; the deque comes up empty, the command queue
//   empty and no response pending; store contents are not cleared
module double_ended_queue_unit
(
    input  logic      clk,
    input  logic      rst_n,
    dqu_req_if.sink   req,
    dqu_rsp_if.source rsp
);

    logic               cmd_valid;
    logic               cmd_take;
    dqu_pkg::cmd_word_t cmd;

    // accept and classify
    dqu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // carry out on the ring store
    dqu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .rsp       (rsp)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // spare action codes, the block answers them with a plain ok
    localparam logic [dqu_pkg::ACT_W-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [dqu_pkg::ACT_W-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [dqu_pkg::ACT_W-1:0] ACT_SPARE_C = 3'd7;

    localparam int RANDOM_ACTIONS = 400;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int IDLE_PERCENT   = 7;

    typedef struct packed {
        logic [dqu_pkg::STAT_W-1:0]        status;
        logic signed [dqu_pkg::DATA_W-1:0] value;
        logic                              last;
        logic [dqu_pkg::OCC_W-1:0]         occ;
    } deque_answer_t;

    typedef struct {
        logic [dqu_pkg::ACT_W-1:0]         act;
        logic signed [dqu_pkg::DATA_W-1:0] val;
        int                                reps;
        bit                                typed;
        logic [dqu_pkg::STAT_W-1:0]        t_status;
        logic signed [dqu_pkg::DATA_W-1:0] t_value;
        logic [dqu_pkg::OCC_W-1:0]         t_occ;
    } stim_row_t;

    logic clk;
    logic rst_n;

    dqu_req_if req ();
    dqu_rsp_if rsp ();

    double_ended_queue_unit i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // mirror of the deque contents
    logic signed [dqu_pkg::DATA_W-1:0] mirror_store [dqu_pkg::DEPTH];
    int                                mirror_front;
    int                                mirror_back;
    int                                mirror_count;

    deque_answer_t answer_fifo [$];
    stim_row_t     dir_table [24];

    bit no_idle;
    int cycle_count = 0;
    int mismatches;
    int words_checked;
    int actions_sent;
    int dump_count;
    int full_refusals;
    int empty_answers;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // work out the answer words of one accepted action
    task automatic apply_deque_action(input logic [dqu_pkg::ACT_W-1:0] act,
                                      input logic signed [dqu_pkg::DATA_W-1:0] val,
                                      input bit record);
        deque_answer_t ans;
        int            idx;
        begin
            actions_sent++;
            ans.status = dqu_pkg::ST_OK;
            ans.value  = '0;
            ans.last   = 1'b1;
            case (act)
                dqu_pkg::ACT_PUSH_FRONT, dqu_pkg::ACT_PUSH_BACK:
                begin
                    if (mirror_count >= dqu_pkg::DEPTH)
                    begin
                        ans.status = dqu_pkg::ST_FULL;
                        full_refusals++;
                    end
                    else if (act == dqu_pkg::ACT_PUSH_FRONT)
                    begin
                        mirror_front = (mirror_front + dqu_pkg::DEPTH - 1) % dqu_pkg::DEPTH;
                        mirror_store[mirror_front] = val;
                        mirror_count++;
                    end
                    else
                    begin
                        mirror_store[mirror_back] = val;
                        mirror_back = (mirror_back + 1) % dqu_pkg::DEPTH;
                        mirror_count++;
                    end
                end
                dqu_pkg::ACT_POP_FRONT, dqu_pkg::ACT_POP_BACK:
                begin
                    if (mirror_count == 0)
                    begin
                        ans.status = dqu_pkg::ST_EMPTY;
                        empty_answers++;
                    end
                    else if (act == dqu_pkg::ACT_POP_FRONT)
                    begin
                        ans.value = mirror_store[mirror_front];
                        mirror_front = (mirror_front + 1) % dqu_pkg::DEPTH;
                        mirror_count--;
                    end
                    else
                    begin
                        mirror_back = (mirror_back + dqu_pkg::DEPTH - 1) % dqu_pkg::DEPTH;
                        ans.value = mirror_store[mirror_back];
                        mirror_count--;
                    end
                end
                dqu_pkg::ACT_DUMP:
                begin
                    dump_count++;
                    if (mirror_count == 0)
                    begin
                        ans.status = dqu_pkg::ST_EMPTY;
                        empty_answers++;
                    end
                end
                default:
                begin
                end
            endcase
            ans.occ = dqu_pkg::OCC_W'(mirror_count);
            if (record)
            begin
                // a dump walks the entries front to back
                if (act == dqu_pkg::ACT_DUMP && mirror_count != 0)
                begin
                    idx = mirror_front;
                    for (int k = 0; k < mirror_count; k++)
                    begin
                        ans.value = mirror_store[idx];
                        ans.last  = (k == mirror_count - 1);
                        answer_fifo.push_back(ans);
                        idx = (idx + 1) % dqu_pkg::DEPTH;
                    end
                end
                else
                begin
                    answer_fifo.push_back(ans);
                end
            end
        end
    endtask

    // offer one word on req and wait for it to be taken
    task automatic send_action(input logic [dqu_pkg::ACT_W-1:0] act,
                               input logic signed [dqu_pkg::DATA_W-1:0] val,
                               input bit record);
        begin
            while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
            end
            req.valid      <= 1'b1;
            req.action     <= act;
            req.push_value <= val;
            @(posedge clk);
            while (!req.ready)
                @(posedge clk);
            apply_deque_action(act, val, record);
        end
    endtask

    // sender holds off until every answer is back
    task automatic hold_until_drained;
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while (answer_fifo.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [dqu_pkg::DATA_W-1:0] want,
                               input logic [dqu_pkg::DATA_W-1:0] got);
        begin
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
            end
        end
    endtask

    // response monitor and random back-pressure
    always @(posedge clk)
    begin
        deque_answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answer_fifo.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got status %0d value 0x%0h",
                         $time, rsp.status, rsp.value_out);
            end
            else
            begin
                want = answer_fifo.pop_front();
                words_checked++;
                check_field("status", dqu_pkg::DATA_W'(want.status),
                            dqu_pkg::DATA_W'(rsp.status));
                check_field("value_out", want.value, rsp.value_out);
                check_field("is_last", dqu_pkg::DATA_W'(want.last),
                            dqu_pkg::DATA_W'(rsp.is_last));
                check_field("occupancy", dqu_pkg::DATA_W'(want.occ),
                            dqu_pkg::DATA_W'(rsp.occupancy));
            end
        end
        rsp.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // run limit
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("double_ended_queue_unit test failed");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [dqu_pkg::ACT_W-1:0]         act;
        logic signed [dqu_pkg::DATA_W-1:0] val;
        deque_answer_t                     typed_ans;
        int                                counted;
        int                                mode;
        int                                roll;
        bit                                held_mid;

        req.valid      <= 1'b0;
        req.action     <= dqu_pkg::ACT_PUSH_FRONT;
        req.push_value <= '0;
        rst_n          <= 1'b0;
        no_idle        = 1'b0;
        mismatches     = 0;
        words_checked  = 0;
        actions_sent   = 0;
        dump_count     = 0;
        full_refusals  = 0;
        empty_answers  = 0;
        mirror_front   = 0;
        mirror_back    = 0;
        mirror_count   = 0;
        held_mid       = 1'b0;

        // directed rows, typed answers only where they are obvious
        dir_table = '{
            '{dqu_pkg::ACT_POP_FRONT, 32'sh0, 1, 1'b1, dqu_pkg::ST_EMPTY, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_POP_BACK, 32'sh0, 1, 1'b1, dqu_pkg::ST_EMPTY, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_DUMP, 32'sh0, 1, 1'b1, dqu_pkg::ST_EMPTY, 32'sh0, 5'd0},
            '{ACT_SPARE_A, 32'sh1357_9bdf, 1, 1'b1, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{ACT_SPARE_B, 32'shffff_ffff, 1, 1'b1, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{ACT_SPARE_C, 32'sh8000_0000, 1, 1'b1, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_PUSH_FRONT, 32'sh7fff_ffff, 1, 1'b1, dqu_pkg::ST_OK, 32'sh0, 5'd1},
            '{dqu_pkg::ACT_PUSH_BACK, 32'sh8000_0000, 1, 1'b1, dqu_pkg::ST_OK, 32'sh0, 5'd2},
            '{dqu_pkg::ACT_DUMP, 32'sh0, 1, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_POP_FRONT, 32'sh0, 1, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_POP_BACK, 32'sh0, 1, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_PUSH_BACK, 32'shffff_ffff, 1, 1'b1, dqu_pkg::ST_OK, 32'sh0, 5'd1},
            '{dqu_pkg::ACT_POP_FRONT, 32'sh0, 1, 1'b1, dqu_pkg::ST_OK, 32'shffff_ffff, 5'd0},
            '{dqu_pkg::ACT_PUSH_FRONT, 32'sh0, 1, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_PUSH_BACK, 32'sh5555_5555, 15, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_PUSH_FRONT, 32'sh1234, 1, 1'b1, dqu_pkg::ST_FULL, 32'sh0, 5'd16},
            '{dqu_pkg::ACT_PUSH_BACK, 32'sh1234, 1, 1'b1, dqu_pkg::ST_FULL, 32'sh0, 5'd16},
            '{dqu_pkg::ACT_DUMP, 32'sh0, 1, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_POP_BACK, 32'sh0, 16, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_POP_BACK, 32'sh0, 1, 1'b1, dqu_pkg::ST_EMPTY, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_PUSH_FRONT, 32'shaaaa_aaaa, 3, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_DUMP, 32'sh0, 1, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_POP_FRONT, 32'sh0, 3, 1'b0, dqu_pkg::ST_OK, 32'sh0, 5'd0},
            '{dqu_pkg::ACT_DUMP, 32'sh0, 1, 1'b1, dqu_pkg::ST_EMPTY, 32'sh0, 5'd0}
        };

        // reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part
        foreach (dir_table[r])
        begin
            for (int k = 0; k < dir_table[r].reps; k++)
            begin
                send_action(dir_table[r].act, dir_table[r].val + k, !dir_table[r].typed);
                if (dir_table[r].typed)
                begin
                    typed_ans.status = dir_table[r].t_status;
                    typed_ans.value  = dir_table[r].t_value;
                    typed_ans.last   = 1'b1;
                    typed_ans.occ    = dir_table[r].t_occ;
                    answer_fifo.push_back(typed_ans);
                end
            end
        end
        hold_until_drained();

        // random part, phases lean toward filling, draining or neither
        counted = 0;
        mode    = 2;
        while (counted < RANDOM_ACTIONS)
        begin
            if (counted % 40 == 0)
                mode = $urandom_range(2);
            no_idle = (counted >= 150 && counted < 260);
            if (counted == RANDOM_ACTIONS / 2 && !held_mid)
            begin
                held_mid = 1'b1;
                hold_until_drained();
            end
            roll = $urandom_range(99);
            if (roll < 5)
                act = dqu_pkg::ACT_DUMP;
            else if (roll < 8)
                act = ACT_SPARE_A + dqu_pkg::ACT_W'($urandom_range(2));
            else if ($urandom_range(99) < (mode == 0 ? 70 : (mode == 1 ? 30 : 50)))
                act = $urandom_range(1) ? dqu_pkg::ACT_PUSH_BACK : dqu_pkg::ACT_PUSH_FRONT;
            else
                act = $urandom_range(1) ? dqu_pkg::ACT_POP_BACK : dqu_pkg::ACT_POP_FRONT;
            case ($urandom_range(15))
                0:       val = 32'sh7fff_ffff;
                1:       val = 32'sh8000_0000;
                2:       val = 32'sh0000_0000;
                3:       val = 32'shffff_ffff;
                default: val = $urandom;
            endcase
            send_action(act, val, 1'b1);
            if (act < ACT_SPARE_A)
                counted++;
        end
        no_idle = 1'b0;
        req.valid <= 1'b0;

        // wait for the last answers, then a little longer
        while (answer_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d actions: %0d dumps, %0d refused pushes, %0d empty answers",
                 actions_sent, dump_count, full_refusals, empty_answers);
        $display("checked %0d response words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("double_ended_queue_unit test passed");
        else
            $display("double_ended_queue_unit test failed");
        $finish;
    end

endmodule

>>> double_ended_queue_unit.f
design/dqu_pkg.sv
design/dqu_if.sv
design/dqu_front.sv
design/dqu_back.sv
design/double_ended_queue_unit.sv
verif/tb_top.sv
